FILE: hw/rtl/lr_pkg.sv
`default_nettype none
package lr_pkg;

  localparam int COORD_W  = 6;
  localparam int COLOR_W  = 8;
  localparam int DIM_W    = 7;
  localparam int ERR_W    = 9;
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 48;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/line_rasterizer.sv
`default_nettype none
// channel   dir  width  contents
// s_*       in   56     tdata: start_x, start_y, end_x, end_y, red, green, blue, alpha
// m_*       out  48     tdata: pixel_x, pixel_y, red, green, blue, alpha;
//                       tuser: write_enable; tlast: last_pixel
// cfg_*     in   7      index 0 frame_width, 1 frame_height
//
// A line gives max(|dx|,|dy|)+1 pixels, one pixel per cycle from the
// error-term step unit while m_tready is high, after a load in idle.
// A new line is taken only once the last pixel of the previous one is out.
// Output stalls hold the current pixel and freeze the walk.
// Reset sets both frame dimensions to 64 and returns to idle.
module line_rasterizer #(
  parameter int FRAME_SIZE = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_index,
  input  wire logic [lr_pkg::DIM_W-1:0]    cfg_wdata,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // start_x, start_y, end_x, end_y, red, green, blue, alpha
  input  wire logic [lr_pkg::S_DATA_W-1:0] s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // pixel_x, pixel_y, out_red, out_green, out_blue, out_alpha
  output logic [lr_pkg::M_DATA_W-1:0]      m_tdata,
  // write_enable
  output logic                             m_tuser,
  output logic                             m_tlast
);
  import lr_pkg::*;

  cmd_t    cmd;
  status_t status;

  lr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lr_datapath #(
    .FRAME_SIZE (FRAME_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/lr_ctrl.sv
`default_nettype none
module lr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output lr_pkg::cmd_t       cmd,
  input  wire lr_pkg::status_t status
);
  import lr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (m_tready && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_WALK: begin
        m_tvalid = 1'b1;
        cmd.step = m_tready && !status.last;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lr_datapath.sv
`default_nettype none
module lr_datapath #(
  parameter int FRAME_SIZE = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_index,
  input  wire logic [lr_pkg::DIM_W-1:0]     cfg_wdata,
  input  wire logic [lr_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire lr_pkg::cmd_t                 cmd,
  output lr_pkg::status_t                   status,
  output logic [lr_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast
);
  import lr_pkg::*;

  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(FRAME_SIZE);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [COORD_W-1:0] x, y, xe, ye, dx, dy;
  logic               stx, sty;
  logic signed [ERR_W-1:0] err;
  logic [COLOR_W-1:0] red, green, blue, alpha;

  logic [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
  logic [COORD_W-1:0] in_dx, in_dy;
  logic signed [ERR_W-1:0] e2, sdx, sdy, err_next;
  logic               step_x, step_y, last;
  logic [DIM_W-1:0]   w_lim, h_lim;
  logic               in_frame;

  assign in_sx = s_tdata[5:0];
  assign in_sy = s_tdata[11:6];
  assign in_ex = s_tdata[17:12];
  assign in_ey = s_tdata[23:18];
  assign in_dx = (in_ex > in_sx) ? (in_ex - in_sx) : (in_sx - in_ex);
  assign in_dy = (in_ey > in_sy) ? (in_ey - in_sy) : (in_sy - in_ey);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sdx = $signed({{(ERR_W-COORD_W){1'b0}}, dx});
  assign sdy = $signed({{(ERR_W-COORD_W){1'b0}}, dy});
  assign e2  = err <<< 1;
  assign step_x = e2 > -sdy;
  assign step_y = e2 < sdx;
  assign err_next = err - (step_x ? sdy : '0) + (step_y ? sdx : '0);
  assign last = (x == xe) && (y == ye);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= in_sx;
      y     <= in_sy;
      xe    <= in_ex;
      ye    <= in_ey;
      dx    <= in_dx;
      dy    <= in_dy;
      stx   <= in_sx < in_ex;
      sty   <= in_sy < in_ey;
      err   <= $signed({{(ERR_W-COORD_W){1'b0}}, in_dx})
             - $signed({{(ERR_W-COORD_W){1'b0}}, in_dy});
      red   <= s_tdata[31:24];
      green <= s_tdata[39:32];
      blue  <= s_tdata[47:40];
      alpha <= s_tdata[55:48];
    end else if (cmd.step) begin
      err <= err_next;
      if (step_x) x <= stx ? x + 1'b1 : x - 1'b1;
      if (step_y) y <= sty ? y + 1'b1 : y - 1'b1;
    end
  end

  assign w_lim  = (frame_width  > DIM_LIMIT) ? DIM_LIMIT : frame_width;
  assign h_lim  = (frame_height > DIM_LIMIT) ? DIM_LIMIT : frame_height;
  assign in_frame = ({1'b0, x} < w_lim) && ({1'b0, y} < h_lim);

  assign status.last = last;
  assign m_tdata = {4'd0, alpha, blue, green, red, y, x};
  assign m_tuser = in_frame && (alpha != '0);
  assign m_tlast = last;

endmodule
`default_nettype wire
